// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, constants and types of the escape-time unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // pixel coordinates
  localparam int COORD_W   = 12;
  localparam int IMAGE_DIM = 4096;

  // iteration count and limit
  localparam int ITER_BITS = 16;

  // fixed point: c is Q4.28, z is sign + 35-bit magnitude of Q8.28
  localparam int Q_FRAC = 28;
  localparam int C_W    = 32;
  localparam int STEP_W = 31;
  localparam int MAP_W  = STEP_W + COORD_W;   // step * coordinate, exact
  localparam int CS_W   = MAP_W + 2;          // origin + step * coordinate
  localparam int MAG_W  = 35;
  localparam int HALF_W = 18;                 // low slice of a multiplier operand
  localparam int PROD_W = 2 * MAG_W;
  localparam int SQ_W   = PROD_W - Q_FRAC;    // product after the Q.28 shift
  localparam int M_W    = SQ_W + 1;           // |z|^2
  localparam int SUM_W  = SQ_W + 4;           // signed update sums

  localparam int ESCAPE_RADIUS_SQ = 1000;
  localparam logic [M_W-1:0]   M_ESCAPE = M_W'(ESCAPE_RADIUS_SQ) << Q_FRAC;
  localparam logic [MAG_W-1:0] Z_MAX    = '1;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_ORIGIN_RE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_IM  = 3'd1;
  localparam logic [IDX_W-1:0] REG_STEP_RE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_STEP_IM    = 3'd3;
  localparam logic [IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

  localparam logic signed [C_W-1:0] RST_ORIGIN = -32'sd536870912;
  localparam logic [STEP_W-1:0]     RST_STEP   = 31'd805306;
  localparam logic [ITER_BITS-1:0]  RST_LIMIT  = 16'd256;

  typedef struct packed {
    logic signed [C_W-1:0]  origin_re;
    logic signed [C_W-1:0]  origin_im;
    logic [STEP_W-1:0]      step_re;
    logic [STEP_W-1:0]      step_im;
    logic [ITER_BITS-1:0]   limit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_px;   // latch pixel coordinates
    logic map;       // step * coordinate
    logic csum;      // c = origin + product, clear z and count
    logic mul_lo;    // partial products, low operand slice
    logic mul_hi;    // partial products, high operand slice, accumulate
    logic update;    // escape test and z update
    logic load_out;  // move result to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lim_hit;
    logic radius_hit;
  } stat_t;

endpackage

// ----- rtl/mbe_if.sv -----
// ----------------------------------------------------------------------------
// mbe_if
// Valid/ready channels for pixels in and escape-time results out.
// ----------------------------------------------------------------------------
interface mbe_in_if;
  logic                        valid;
  logic                        ready;
  logic [mbe_pkg::COORD_W-1:0] column;
  logic [mbe_pkg::COORD_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface mbe_out_if;
  logic                          valid;
  logic                          ready;
  logic [mbe_pkg::COORD_W-1:0]   out_column;
  logic [mbe_pkg::COORD_W-1:0]   out_row;
  logic [mbe_pkg::ITER_BITS-1:0] iteration_count;
  logic                          escaped;

  modport source (output valid, output out_column, output out_row,
                  output iteration_count, output escaped, input ready);
  modport sink   (input valid, input out_column, input out_row,
                  input iteration_count, input escaped, output ready);
endinterface

// ----- rtl/mbe_regs.sv -----
// ----------------------------------------------------------------------------
// mbe_regs
// APB-style register bank: view origin, pixel step, iteration limit.
// ----------------------------------------------------------------------------
module mbe_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mbe_pkg::cfg_t               cfg
);

  mbe_pkg::cfg_t                  cfg_r, cfg_nxt;
  logic                           wr_en;
  logic [mbe_pkg::IDX_W-1:0]      idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[mbe_pkg::ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        mbe_pkg::REG_ORIGIN_RE:  cfg_nxt.origin_re = signed'(pwdata);
        mbe_pkg::REG_ORIGIN_IM:  cfg_nxt.origin_im = signed'(pwdata);
        mbe_pkg::REG_STEP_RE:    cfg_nxt.step_re   = pwdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_STEP_IM:    cfg_nxt.step_im   = pwdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_ITER_LIMIT: cfg_nxt.limit     = pwdata[mbe_pkg::ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re <= mbe_pkg::RST_ORIGIN;
      cfg_r.origin_im <= mbe_pkg::RST_ORIGIN;
      cfg_r.step_re   <= mbe_pkg::RST_STEP;
      cfg_r.step_im   <= mbe_pkg::RST_STEP;
      cfg_r.limit     <= mbe_pkg::RST_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      mbe_pkg::REG_ORIGIN_RE:  prdata = cfg_r.origin_re;
      mbe_pkg::REG_ORIGIN_IM:  prdata = cfg_r.origin_im;
      mbe_pkg::REG_STEP_RE:    prdata = mbe_pkg::DATA_W'(cfg_r.step_re);
      mbe_pkg::REG_STEP_IM:    prdata = mbe_pkg::DATA_W'(cfg_r.step_im);
      mbe_pkg::REG_ITER_LIMIT: prdata = mbe_pkg::DATA_W'(cfg_r.limit);
      default:                 prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: pixel mapping, per-pass multiply/update steps, result handoff.
// ----------------------------------------------------------------------------
module mbe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mbe_pkg::stat_t stat,
  output mbe_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_CSUM = 3'd2;
  localparam logic [2:0] S_MUL0 = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       stop;

  assign slot_free = !out_valid_r || out_ready;
  assign stop      = stat.lim_hit || stat.radius_hit;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_px = 1'b1;
          state_nxt   = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = S_CSUM;
      end
      S_CSUM: begin
        cmd.csum  = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = stop ? S_FIN : S_MUL0;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_px, cmd.map, cmd.csum, cmd.mul_lo, cmd.mul_hi,
              cmd.update, cmd.load_out}))
    else $error("more than one datapath command in a cycle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken transaction");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MAP))
    else $error("accepted pixel did not start mapping");

  a_pass_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !stop) |=> (state_r == S_MUL0))
    else $error("counted pass did not start another pass");
`endif

endmodule

// ----- rtl/mbe_dpath.sv -----
// ----------------------------------------------------------------------------
// mbe_dpath
// Datapath: c mapping, three split multiplier lanes, z update, result register.
// ----------------------------------------------------------------------------
module mbe_dpath (
  input  logic                          clk,
  input  mbe_pkg::cfg_t                 cfg,
  input  logic [mbe_pkg::COORD_W-1:0]   in_column,
  input  logic [mbe_pkg::COORD_W-1:0]   in_row,
  input  mbe_pkg::cmd_t                 cmd,
  output mbe_pkg::stat_t                stat,
  output logic [mbe_pkg::COORD_W-1:0]   out_column,
  output logic [mbe_pkg::COORD_W-1:0]   out_row,
  output logic [mbe_pkg::ITER_BITS-1:0] iteration_count,
  output logic                          escaped
);

  localparam int NLANE = 3;
  localparam int LO_PW = mbe_pkg::MAG_W + mbe_pkg::HALF_W;
  localparam int HI_PW = 2 * mbe_pkg::MAG_W - mbe_pkg::HALF_W;

  // coordinates past the image edge map as the last pixel
  function automatic logic [mbe_pkg::COORD_W-1:0] clip_coord(
    input logic [mbe_pkg::COORD_W-1:0] v);
    if (int'(v) >= mbe_pkg::IMAGE_DIM) begin
      return mbe_pkg::COORD_W'(mbe_pkg::IMAGE_DIM - 1);
    end
    return v;
  endfunction

  function automatic logic signed [mbe_pkg::C_W-1:0] sat_c(
    input logic signed [mbe_pkg::CS_W-1:0] v);
    logic [mbe_pkg::CS_W-mbe_pkg::C_W:0] top;
    top = v[mbe_pkg::CS_W-1:mbe_pkg::C_W-1];
    if ((&top) || !(|top)) begin
      return v[mbe_pkg::C_W-1:0];
    end
    return v[mbe_pkg::CS_W-1] ? {1'b1, {(mbe_pkg::C_W-1){1'b0}}}
                              : {1'b0, {(mbe_pkg::C_W-1){1'b1}}};
  endfunction

  function automatic logic [mbe_pkg::MAG_W-1:0] sat_mag(
    input logic [mbe_pkg::SUM_W-1:0] v);
    return (|v[mbe_pkg::SUM_W-1:mbe_pkg::MAG_W]) ? mbe_pkg::Z_MAX
                                                 : v[mbe_pkg::MAG_W-1:0];
  endfunction

  logic [mbe_pkg::COORD_W-1:0]   col_r, row_r;
  logic [mbe_pkg::MAP_W-1:0]     mre_r, mim_r;
  logic signed [mbe_pkg::C_W-1:0] cr_r, ci_r;
  logic                          zr_s_r, zi_s_r;
  logic [mbe_pkg::MAG_W-1:0]     zr_m_r, zi_m_r;
  logic [mbe_pkg::PROD_W-1:0]    prod_r [NLANE];
  logic [mbe_pkg::ITER_BITS-1:0] cnt_r;
  logic                          esc_r;
  logic [mbe_pkg::COORD_W-1:0]   ocol_r, orow_r;
  logic [mbe_pkg::ITER_BITS-1:0] ocnt_r;
  logic                          oesc_r;

  logic signed [mbe_pkg::CS_W-1:0] cs_re, cs_im;

  logic [mbe_pkg::MAG_W-1:0] lane_a [NLANE];
  logic [mbe_pkg::MAG_W-1:0] lane_b [NLANE];
  logic [LO_PW-1:0]          plo [NLANE];
  logic [HI_PW-1:0]          phi [NLANE];

  logic [mbe_pkg::SQ_W-1:0]        sq_rr, sq_ii, sq_ri;
  logic [mbe_pkg::M_W-1:0]         mag_sq;
  logic signed [mbe_pkg::SUM_W-1:0] r2, i2, p2, cre, cim;
  logic signed [mbe_pkg::SUM_W-1:0] re_sum, re_neg, im_sum, im_neg;
  logic                            ri_neg;
  logic                            stop;

  // c = origin + step * coordinate, exact, then saturated to Q4.28
  assign cs_re = mbe_pkg::CS_W'(cfg.origin_re) + mbe_pkg::CS_W'(signed'({1'b0, mre_r}));
  assign cs_im = mbe_pkg::CS_W'(cfg.origin_im) + mbe_pkg::CS_W'(signed'({1'b0, mim_r}));

  // lanes: re*re, im*im, re*im on magnitudes, operand b split in two slices
  always_comb begin
    lane_a[0] = zr_m_r;  lane_b[0] = zr_m_r;
    lane_a[1] = zi_m_r;  lane_b[1] = zi_m_r;
    lane_a[2] = zr_m_r;  lane_b[2] = zi_m_r;
    for (int k = 0; k < NLANE; k++) begin
      plo[k] = lane_a[k] * lane_b[k][mbe_pkg::HALF_W-1:0];
      phi[k] = lane_a[k] * lane_b[k][mbe_pkg::MAG_W-1:mbe_pkg::HALF_W];
    end
  end

  // truncation toward zero: shift the magnitude, apply the sign afterwards
  assign sq_rr  = prod_r[0][mbe_pkg::PROD_W-1:mbe_pkg::Q_FRAC];
  assign sq_ii  = prod_r[1][mbe_pkg::PROD_W-1:mbe_pkg::Q_FRAC];
  assign sq_ri  = prod_r[2][mbe_pkg::PROD_W-1:mbe_pkg::Q_FRAC];
  assign mag_sq = mbe_pkg::M_W'(sq_rr) + mbe_pkg::M_W'(sq_ii);

  assign r2     = signed'(mbe_pkg::SUM_W'(sq_rr));
  assign i2     = signed'(mbe_pkg::SUM_W'(sq_ii));
  assign p2     = signed'(mbe_pkg::SUM_W'({sq_ri, 1'b0}));
  assign cre    = mbe_pkg::SUM_W'(cr_r);
  assign cim    = mbe_pkg::SUM_W'(ci_r);
  assign ri_neg = zr_s_r ^ zi_s_r;

  // sum and its negation side by side, so the magnitude needs no extra adder
  assign re_sum = r2 - i2 + cre;
  assign re_neg = i2 - r2 - cre;
  assign im_sum = ri_neg ? (cim - p2) : (cim + p2);
  assign im_neg = ri_neg ? (p2 - cim) : (-cim - p2);

  assign stat.lim_hit    = cnt_r >= cfg.limit;
  assign stat.radius_hit = mag_sq >= mbe_pkg::M_ESCAPE;
  assign stop            = stat.lim_hit || stat.radius_hit;

  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      col_r <= in_column;
      row_r <= in_row;
    end
    if (cmd.map) begin
      mre_r <= cfg.step_re * clip_coord(col_r);
      mim_r <= cfg.step_im * clip_coord(row_r);
    end
    if (cmd.csum) begin
      cr_r   <= sat_c(cs_re);
      ci_r   <= sat_c(cs_im);
      zr_s_r <= 1'b0;
      zi_s_r <= 1'b0;
      zr_m_r <= '0;
      zi_m_r <= '0;
      cnt_r  <= '0;
    end
    for (int k = 0; k < NLANE; k++) begin
      if (cmd.mul_lo) begin
        prod_r[k] <= mbe_pkg::PROD_W'(plo[k]);
      end else if (cmd.mul_hi) begin
        prod_r[k] <= prod_r[k] + (mbe_pkg::PROD_W'(phi[k]) << mbe_pkg::HALF_W);
      end
    end
    if (cmd.update) begin
      if (stop) begin
        esc_r <= !stat.lim_hit;
      end else begin
        cnt_r  <= cnt_r + 1'b1;
        zr_s_r <= re_sum[mbe_pkg::SUM_W-1];
        zr_m_r <= sat_mag(re_sum[mbe_pkg::SUM_W-1] ? re_neg : re_sum);
        zi_s_r <= im_sum[mbe_pkg::SUM_W-1];
        zi_m_r <= sat_mag(im_sum[mbe_pkg::SUM_W-1] ? im_neg : im_sum);
      end
    end
    if (cmd.load_out) begin
      ocol_r <= col_r;
      orow_r <= row_r;
      ocnt_r <= cnt_r;
      oesc_r <= esc_r;
    end
  end

  assign out_column      = ocol_r;
  assign out_row         = orow_r;
  assign iteration_count = ocnt_r;
  assign escaped         = oesc_r;

endmodule

// ----- rtl/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration for one pixel at a time, Q4.28 view set over APB.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+--------------------------------------
//  in_ch    | in  | valid / ready     | column[11:0], row[11:0]
//  out_ch   | out | valid / ready     | out_column, out_row,
//           |     |                   | iteration_count[15:0], escaped
//  apb      | in  | psel/penable      | paddr[4:0], pwdata/prdata[31:0]
//
//  Steps: acceptance, map, c sum, then passes of two multiplier slices
//  and one update each, then the handoff. A new pixel is taken only once
//  the last one has been handed off. The pass loop on the split 35x18
//  multiplier lanes dominates the time per pixel.
//  Reset: synchronous, active low; clears the sequencer and the result
//  valid, and loads the register defaults. No clearing pass.
//  Stalls: the result sits in an output register; the next pixel is taken
//  while it waits. A pixel that finishes with the register still full waits.
//
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
  input  logic                        clk,
  input  logic                        rst_n,
  mbe_in_if.sink                      in_ch,
  mbe_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  mbe_pkg::cfg_t  cfg;
  mbe_pkg::cmd_t  cmd;
  mbe_pkg::stat_t stat;

  // register bank; the user must make writes land only between pixels, the bank does not enforce it
  mbe_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: owns both handshakes and steps the datapath
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and result register; z kept as sign + saturated magnitude
  mbe_dpath u_dpath (
    .clk             (clk),
    .cfg             (cfg),
    .in_column       (in_ch.column),
    .in_row          (in_ch.row),
    .cmd             (cmd),
    .stat            (stat),
    .out_column      (out_ch.out_column),
    .out_row         (out_ch.out_row),
    .iteration_count (out_ch.iteration_count),
    .escaped         (out_ch.escaped)
  );

endmodule
